// ===== design/rgq_pkg.sv =====
// shared types, constants and helpers for the ground quad ray hit test
// depends on nothing; imported by the controller, the datapath and the top
`timescale 1ns / 1ps

package rgq_pkg;

    // fixed point and sizing
    localparam int FRAC_BITS     = 16;
    localparam int MAX_TRIANGLES = 16;
    localparam int MAX_GROUNDS   = 256;
    localparam int VTX_DEPTH     = MAX_TRIANGLES * 3;
    localparam int VTX_AW        = $clog2(VTX_DEPTH);
    localparam int GC_W          = $clog2(MAX_GROUNDS + 1);
    localparam int DIV_STEPS     = FRAC_BITS + 1;
    localparam int DIV_CW        = $clog2(DIV_STEPS);
    localparam int RATE_W        = FRAC_BITS + 1;
    localparam int CFG_IW        = 3;

    // input modes
    localparam logic [1:0] MODE_BEGIN = 2'd0;
    localparam logic [1:0] MODE_VERTEX = 2'd1;
    localparam logic [1:0] MODE_GROUND = 2'd2;
    localparam logic [1:0] MODE_END = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IW-1:0] CFG_DIR_X    = 3'd0;
    localparam logic [CFG_IW-1:0] CFG_DIR_Y    = 3'd1;
    localparam logic [CFG_IW-1:0] CFG_DIR_Z    = 3'd2;
    localparam logic [CFG_IW-1:0] CFG_LENGTH   = 3'd3;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_X = 3'd4;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_Y = 3'd5;
    localparam logic [CFG_IW-1:0] CFG_OFFSET_Z = 3'd6;

    // datapath operations
    typedef logic [4:0] t_op;
    localparam t_op OP_NONE   = 5'd0;
    localparam t_op OP_START  = 5'd1;
    localparam t_op OP_CLRACC = 5'd2;
    localparam t_op OP_CEN    = 5'd3;
    localparam t_op OP_END    = 5'd4;
    localparam t_op OP_DS     = 5'd5;
    localparam t_op OP_DE     = 5'd6;
    localparam t_op OP_DIVI   = 5'd7;
    localparam t_op OP_DIV    = 5'd8;
    localparam t_op OP_HD     = 5'd9;
    localparam t_op OP_HIT    = 5'd10;
    localparam t_op OP_VLD    = 5'd11;
    localparam t_op OP_EH     = 5'd12;
    localparam t_op OP_M1     = 5'd13;
    localparam t_op OP_M2     = 5'd14;
    localparam t_op OP_DCLR   = 5'd15;
    localparam t_op OP_DOT    = 5'd16;
    localparam t_op OP_OUT    = 5'd17;

    // payloads
    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] coord_x;
        logic signed [31:0] coord_y;
        logic signed [31:0] coord_z;
    } t_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [7:0]         hit_ground;
    } t_out;

    // controller to datapath
    typedef struct packed {
        t_op               op;
        logic [1:0]        k;
        logic [1:0]        i;
        logic              ph;
        logic [VTX_AW-1:0] addr;
        logic              we;
        logic              load_in;
        logic              hit;
        logic [7:0]        ground;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic cross_fail;
        logic edge_zero;
        logic dot_pos;
    } t_sts;

    // next axis modulo three
    function automatic logic [1:0] next3(input logic [1:0] v);
        logic [1:0] r;
        r = (v == 2'd2) ? 2'd0 : v + 2'd1;
        return r;
    endfunction

    // saturate to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [65:0] x);
        logic signed [31:0] r;
        if (x > 66'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (x < -66'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage

// ===== design/rgq_ram.sv =====
// generic simple dual port ram with registered read
// no dependencies
`timescale 1ns / 1ps

module rgq_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== design/rgq_dp.sv =====
// datapath: config registers, vertex ram, shared multiplier, divider, result register
// depends on rgq_pkg and rgq_ram
`timescale 1ns / 1ps

module rgq_dp
    import rgq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data,
    input  t_in               i_in,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output t_out              o_out
);

    logic signed [31:0] r_dir [3];
    logic signed [31:0] r_off [3];
    logic [30:0]        r_len;
    logic signed [31:0] r_crd [3];
    logic signed [31:0] r_start [3];
    logic signed [33:0] r_csum [3];
    logic signed [31:0] r_end [3];
    logic signed [49:0] r_ds, r_de;
    logic [52:0]        r_rem;
    logic [51:0]        r_dv;
    logic               r_dz;
    logic [RATE_W-1:0]  r_rate;
    logic [30:0]        r_hd;
    logic signed [31:0] r_hp [3];
    logic signed [31:0] r_p [3][3];
    logic signed [31:0] r_e [3];
    logic signed [31:0] r_h [3];
    logic signed [63:0] r_m1;
    logic               r_zero;
    logic signed [31:0] r_c [3][3];
    logic signed [63:0] r_d;
    logic signed [65:0] r_prod;
    t_out               r_out;

    logic [95:0]        w_rdata;
    logic [1:0]         w_a, w_b, w_j, w_k;
    logic signed [32:0] w_ma, w_mb;
    logic signed [31:0] w_cen;
    logic signed [65:0] w_sh;
    logic signed [51:0] w_num, w_den;
    logic               w_take;
    logic [52:0]        w_rsub;

    // vertex store, one vertex per entry as {z, y, x}
    rgq_ram #(.WIDTH(96), .DEPTH(VTX_DEPTH)) u_vram (
        .i_clk  (i_clk),
        .i_we   (i_cmd.we),
        .i_waddr(i_cmd.addr),
        .i_wdata({r_crd[2], r_crd[1], r_crd[0]}),
        .i_raddr(i_cmd.addr),
        .o_rdata(w_rdata)
    );

    assign w_k   = i_cmd.k;
    assign w_a   = next3(w_k);
    assign w_b   = next3(w_a);
    assign w_j   = next3(i_cmd.i);
    assign w_cen = r_csum[w_k][33:2];
    assign w_sh  = r_prod >>> FRAC_BITS;

    // multiplier operand selection
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (i_cmd.op)
            OP_END: begin
                w_ma = 33'(r_dir[w_k]);
                w_mb = 33'(r_len);
            end
            OP_DS: begin
                w_ma = 33'(r_crd[w_k]);
                w_mb = 33'(sat32(66'(r_start[w_k]) - 66'(w_cen)));
            end
            OP_DE: begin
                w_ma = 33'(r_crd[w_k]);
                w_mb = 33'(sat32(66'(r_end[w_k]) - 66'(w_cen)));
            end
            OP_HD: begin
                w_ma = 33'(r_len);
                w_mb = 33'(r_rate);
            end
            OP_HIT: begin
                w_ma = 33'(r_dir[w_k]);
                w_mb = 33'(r_hd);
            end
            OP_M1: begin
                w_ma = 33'(r_e[w_a]);
                w_mb = 33'(r_h[w_b]);
            end
            OP_M2: begin
                w_ma = 33'(r_e[w_b]);
                w_mb = 33'(r_h[w_a]);
            end
            OP_DOT: begin
                w_ma = 33'(r_c[i_cmd.i][w_k]);
                w_mb = 33'(r_c[w_j][w_k]);
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    // division setup and one restoring step
    always_comb begin
        w_den = 52'(r_ds) - 52'(r_de);
        w_num = 52'(r_ds);
        if (w_den < 0) begin
            w_num = -w_num;
            w_den = -w_den;
        end
        if (w_num < 0) begin
            w_num = '0;
        end
        w_take = !r_dz && (r_rem >= 53'(r_dv));
        w_rsub = w_take ? r_rem - 53'(r_dv) : r_rem;
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir[0] <= '0;
            r_dir[1] <= -32'sd65536;
            r_dir[2] <= '0;
            r_len    <= 31'd65536;
            r_off[0] <= '0;
            r_off[1] <= '0;
            r_off[2] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DIR_X:    r_dir[0] <= i_cfg_data;
                CFG_DIR_Y:    r_dir[1] <= i_cfg_data;
                CFG_DIR_Z:    r_dir[2] <= i_cfg_data;
                CFG_LENGTH:   r_len    <= i_cfg_data[30:0];
                CFG_OFFSET_X: r_off[0] <= i_cfg_data;
                CFG_OFFSET_Y: r_off[1] <= i_cfg_data;
                CFG_OFFSET_Z: r_off[2] <= i_cfg_data;
                default:      ;
            endcase
        end
    end

    // state that the model resets
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start[0] <= '0;
            r_start[1] <= '0;
            r_start[2] <= '0;
            r_hp[0]    <= '0;
            r_hp[1]    <= '0;
            r_hp[2]    <= '0;
        end else begin
            if (i_cmd.op == OP_START) begin
                for (int k = 0; k < 3; k++) begin
                    r_start[k] <= sat32(66'(r_crd[k]) + 66'(r_off[k]));
                end
            end
            if (i_cmd.op == OP_HIT && i_cmd.ph) begin
                r_hp[w_k] <= sat32(66'(r_start[w_k]) + w_sh);
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_crd[0] <= i_in.coord_x;
            r_crd[1] <= i_in.coord_y;
            r_crd[2] <= i_in.coord_z;
        end
        if (!i_cmd.ph) begin
            r_prod <= w_ma * w_mb;
        end
        case (i_cmd.op)
            OP_CLRACC: begin
                for (int k = 0; k < 3; k++) begin
                    r_csum[k] <= '0;
                end
                r_ds <= '0;
                r_de <= '0;
            end
            OP_CEN: begin
                for (int k = 0; k < 3; k++) begin
                    r_csum[k] <= r_csum[k] + 34'(signed'(w_rdata[32*k +: 32]));
                end
            end
            OP_END: begin
                if (i_cmd.ph) begin
                    r_end[w_k] <= sat32(66'(r_start[w_k]) + 66'(sat32(w_sh)));
                end
            end
            OP_DS: begin
                if (i_cmd.ph) begin
                    r_ds <= r_ds + w_sh[49:0];
                end
            end
            OP_DE: begin
                if (i_cmd.ph) begin
                    r_de <= r_de + w_sh[49:0];
                end
            end
            OP_DIVI: begin
                r_rem  <= 53'(unsigned'(w_num));
                r_dv   <= unsigned'(w_den);
                r_dz   <= (w_den == 0);
                r_rate <= '0;
            end
            OP_DIV: begin
                r_rem  <= {w_rsub[51:0], 1'b0};
                r_rate <= {r_rate[RATE_W-2:0], w_take};
            end
            OP_HD: begin
                if (i_cmd.ph) begin
                    r_hd <= r_prod[FRAC_BITS+30:FRAC_BITS];
                end
            end
            OP_VLD: begin
                for (int k = 0; k < 3; k++) begin
                    r_p[i_cmd.i][k] <= w_rdata[32*k +: 32];
                end
            end
            OP_EH: begin
                for (int k = 0; k < 3; k++) begin
                    r_e[k] <= sat32(66'(r_p[w_j][k]) - 66'(r_p[i_cmd.i][k]));
                    r_h[k] <= sat32(66'(r_hp[k]) - 66'(r_p[i_cmd.i][k]));
                end
                r_zero <= 1'b1;
            end
            OP_M1: begin
                if (i_cmd.ph) begin
                    r_m1 <= r_prod[63:0];
                end
            end
            OP_M2: begin
                if (i_cmd.ph) begin
                    if (r_m1 != r_prod[63:0]) begin
                        r_zero <= 1'b0;
                    end
                    r_c[i_cmd.i][w_k] <= sat32((66'(r_m1) >>> FRAC_BITS) - w_sh);
                end
            end
            OP_DCLR: begin
                r_d <= '0;
            end
            OP_DOT: begin
                if (i_cmd.ph) begin
                    r_d <= r_d + r_prod[65:2];
                end
            end
            default: ;
        endcase
    end

    // result register, control is in the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_OUT) begin
            r_out.hit        <= i_cmd.hit;
            r_out.hit_x      <= r_hp[0];
            r_out.hit_y      <= r_hp[1];
            r_out.hit_z      <= r_hp[2];
            r_out.hit_ground <= i_cmd.hit ? i_cmd.ground : 8'd0;
        end
    end

    // status back to the controller
    assign o_sts.cross_fail = ((r_ds > 0) && (r_de > 0)) || ((r_ds < 0) && (r_de < 0));
    assign o_sts.edge_zero  = r_zero;
    assign o_sts.dot_pos    = (r_d > 0);
    assign o_out            = r_out;

endmodule

// ===== design/rgq_ctrl.sv =====
// controller: sequences queries, ground evaluation and triangle tests
// depends on rgq_pkg
`timescale 1ns / 1ps

module rgq_ctrl
    import rgq_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic [1:0] i_mode,
    output logic       o_in_stall,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    input  t_sts       i_sts,
    output t_cmd       o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DISP = 5'd1;
    localparam logic [4:0] S_CEN  = 5'd2;
    localparam logic [4:0] S_END  = 5'd3;
    localparam logic [4:0] S_DS   = 5'd4;
    localparam logic [4:0] S_DE   = 5'd5;
    localparam logic [4:0] S_XCHK = 5'd6;
    localparam logic [4:0] S_DIV  = 5'd7;
    localparam logic [4:0] S_HD   = 5'd8;
    localparam logic [4:0] S_HIT  = 5'd9;
    localparam logic [4:0] S_TLD  = 5'd10;
    localparam logic [4:0] S_EH   = 5'd11;
    localparam logic [4:0] S_MUL  = 5'd12;
    localparam logic [4:0] S_ZCHK = 5'd13;
    localparam logic [4:0] S_DOT  = 5'd14;
    localparam logic [4:0] S_DCHK = 5'd15;
    localparam logic [4:0] S_FIN  = 5'd16;

    logic [4:0]        r_state, n_state;
    logic [1:0]        r_mode, n_mode;
    logic [2:0]        r_s, n_s;
    logic [1:0]        r_k, n_k;
    logic              r_ph, n_ph;
    logic              r_sub, n_sub;
    logic [1:0]        r_i, n_i;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [VTX_AW-1:0] r_vb, n_vb;
    logic [VTX_AW-1:0] r_vcount, n_vcount;
    logic [GC_W-1:0]   r_gc, n_gc;
    logic [7:0]        r_hg, n_hg;
    logic              r_hit, n_hit;
    logic              r_fd, n_fd;
    logic              r_oval, n_oval;
    logic              w_axis_last;

    assign w_axis_last = r_ph && (r_k == 2'd2);

    // next state and command
    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_s      = r_s;
        n_k      = r_k;
        n_ph     = r_ph;
        n_sub    = r_sub;
        n_i      = r_i;
        n_cnt    = r_cnt;
        n_vb     = r_vb;
        n_vcount = r_vcount;
        n_gc     = r_gc;
        n_hg     = r_hg;
        n_hit    = r_hit;
        n_fd     = r_fd;
        n_oval   = (r_oval && !i_out_stall) ? 1'b0 : r_oval;

        o_cmd         = '0;
        o_cmd.op      = OP_NONE;
        o_cmd.k       = r_k;
        o_cmd.i       = r_i;
        o_cmd.ph      = r_ph;
        o_cmd.hit     = r_hit;
        o_cmd.ground  = r_hg;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_mode        = i_mode;
                    n_state       = S_DISP;
                end
            end
            S_DISP: begin
                unique case (r_mode)
                    MODE_BEGIN: begin
                        o_cmd.op = OP_START;
                        n_vcount = '0;
                        n_gc     = '0;
                        n_fd     = 1'b0;
                        n_state  = S_IDLE;
                    end
                    MODE_VERTEX: begin
                        if (r_vcount < VTX_AW'(VTX_DEPTH)) begin
                            o_cmd.we   = 1'b1;
                            o_cmd.addr = r_vcount;
                            n_vcount   = r_vcount + 1'b1;
                        end
                        n_state = S_IDLE;
                    end
                    MODE_GROUND: begin
                        if (!r_fd && (r_gc < GC_W'(MAX_GROUNDS)) && (r_vcount >= VTX_AW'(6))) begin
                            o_cmd.op = OP_CLRACC;
                            n_s      = '0;
                            n_state  = S_CEN;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    MODE_END: begin
                        if (!r_oval || !i_out_stall) begin
                            o_cmd.op = OP_OUT;
                            n_oval   = 1'b1;
                            n_state  = S_IDLE;
                        end
                    end
                    default: ;
                endcase
            end
            // quad corners are vertices 0, 1, 4 and 5
            S_CEN: begin
                case (r_s)
                    3'd0:    o_cmd.addr = VTX_AW'(0);
                    3'd1:    o_cmd.addr = VTX_AW'(1);
                    3'd2:    o_cmd.addr = VTX_AW'(4);
                    3'd3:    o_cmd.addr = VTX_AW'(5);
                    default: o_cmd.addr = '0;
                endcase
                if (r_s != 3'd0) begin
                    o_cmd.op = OP_CEN;
                end
                n_s = r_s + 3'd1;
                if (r_s == 3'd4) begin
                    n_k     = '0;
                    n_ph    = 1'b0;
                    n_state = S_END;
                end
            end
            S_END, S_DS, S_DE, S_HIT: begin
                case (r_state)
                    S_END:   o_cmd.op = OP_END;
                    S_DS:    o_cmd.op = OP_DS;
                    S_DE:    o_cmd.op = OP_DE;
                    default: o_cmd.op = OP_HIT;
                endcase
                n_ph = !r_ph;
                if (r_ph) begin
                    n_k = r_k + 2'd1;
                end
                if (w_axis_last) begin
                    n_k = '0;
                    case (r_state)
                        S_END:   n_state = S_DS;
                        S_DS:    n_state = S_DE;
                        S_DE:    n_state = S_XCHK;
                        default: begin
                            n_vb    = '0;
                            n_s     = '0;
                            n_state = S_TLD;
                        end
                    endcase
                end
            end
            S_XCHK: begin
                if (i_sts.cross_fail) begin
                    n_hit   = 1'b0;
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_DIVI;
                    n_cnt    = '0;
                    n_state  = S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.op = OP_DIV;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == DIV_CW'(DIV_STEPS - 1)) begin
                    n_ph    = 1'b0;
                    n_state = S_HD;
                end
            end
            S_HD: begin
                o_cmd.op = OP_HD;
                n_ph     = !r_ph;
                if (r_ph) begin
                    n_k     = '0;
                    n_state = S_HIT;
                end
            end
            // fetch the three vertices of one triangle
            S_TLD: begin
                o_cmd.addr = r_vb + VTX_AW'(r_s);
                if (r_s != 3'd0) begin
                    o_cmd.op = OP_VLD;
                    o_cmd.i  = 2'(r_s - 3'd1);
                end
                n_s = r_s + 3'd1;
                if (r_s == 3'd3) begin
                    n_i     = '0;
                    n_state = S_EH;
                end
            end
            S_EH: begin
                o_cmd.op = OP_EH;
                n_k      = '0;
                n_ph     = 1'b0;
                n_sub    = 1'b0;
                n_state  = S_MUL;
            end
            S_MUL: begin
                o_cmd.op = r_sub ? OP_M2 : OP_M1;
                n_ph     = !r_ph;
                if (r_ph) begin
                    n_sub = !r_sub;
                    if (r_sub) begin
                        n_k = r_k + 2'd1;
                        if (r_k == 2'd2) begin
                            n_state = S_ZCHK;
                        end
                    end
                end
            end
            S_ZCHK: begin
                if (i_sts.edge_zero) begin
                    n_hit   = 1'b1;
                    n_fd    = 1'b1;
                    n_hg    = r_gc[7:0];
                    n_state = S_FIN;
                end else if (r_i == 2'd2) begin
                    o_cmd.op = OP_DCLR;
                    n_i      = '0;
                    n_k      = '0;
                    n_ph     = 1'b0;
                    n_state  = S_DOT;
                end else begin
                    n_i     = r_i + 2'd1;
                    n_state = S_EH;
                end
            end
            S_DOT: begin
                o_cmd.op = OP_DOT;
                n_ph     = !r_ph;
                if (r_ph) begin
                    n_k = r_k + 2'd1;
                end
                if (w_axis_last) begin
                    n_k     = '0;
                    n_state = S_DCHK;
                end
            end
            S_DCHK: begin
                if (!i_sts.dot_pos) begin
                    // this triangle misses, try the next whole one
                    n_vb = r_vb + VTX_AW'(3);
                    n_s  = '0;
                    if (({1'b0, r_vb} + (VTX_AW+1)'(6)) <= {1'b0, r_vcount}) begin
                        n_state = S_TLD;
                    end else begin
                        n_hit   = 1'b0;
                        n_state = S_FIN;
                    end
                end else if (r_i == 2'd2) begin
                    n_hit   = 1'b1;
                    n_fd    = 1'b1;
                    n_hg    = r_gc[7:0];
                    n_state = S_FIN;
                end else begin
                    o_cmd.op = OP_DCLR;
                    n_i      = r_i + 2'd1;
                    n_state  = S_DOT;
                end
            end
            S_FIN: begin
                if (r_gc < GC_W'(MAX_GROUNDS)) begin
                    n_gc = r_gc + 1'b1;
                end
                n_vcount = '0;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mode   <= MODE_BEGIN;
            r_s      <= '0;
            r_k      <= '0;
            r_ph     <= 1'b0;
            r_sub    <= 1'b0;
            r_i      <= '0;
            r_cnt    <= '0;
            r_vb     <= '0;
            r_vcount <= '0;
            r_gc     <= '0;
            r_hg     <= '0;
            r_hit    <= 1'b0;
            r_fd     <= 1'b0;
            r_oval   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_mode   <= n_mode;
            r_s      <= n_s;
            r_k      <= n_k;
            r_ph     <= n_ph;
            r_sub    <= n_sub;
            r_i      <= n_i;
            r_cnt    <= n_cnt;
            r_vb     <= n_vb;
            r_vcount <= n_vcount;
            r_gc     <= n_gc;
            r_hg     <= n_hg;
            r_hit    <= n_hit;
            r_fd     <= n_fd;
            r_oval   <= n_oval;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_oval;

endmodule

// ===== design/ray_ground_quad_hit_test_top.sv =====
// Ground quad ray hit test. A query casts a segment from the owner position plus an
// offset along direction times length, then grounds stream in as triangle vertices
// closed by a normal; the first ground whose triangles contain the plane crossing
// ends the search, and an end-of-query transaction returns one result. An
// end-of-ground transaction that is evaluated is paced by the single shared 33x33
// multiplier and the one-bit-per-cycle divider for the crossing rate.
// The result register lets the next transaction enter while a result waits.
// depends on rgq_pkg, rgq_ctrl, rgq_dp
`timescale 1ns / 1ps

module ray_ground_quad_hit_test_top
    import rgq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in               i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out              o_out_data,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_IW-1:0] i_cfg_index,
    input  logic [31:0]       i_cfg_data
);

    t_cmd w_cmd;
    t_sts w_sts;

    // configuration is always accepted
    assign o_cfg_ready = 1'b1;

    // sequencer
    rgq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_mode     (i_in_data.mode),
        .o_in_stall (o_in_stall),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic and storage
    rgq_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_out      (o_out_data)
    );

endmodule
